### sv/clm_pkg.sv
package clm_pkg;

    localparam int NUM_COMMANDS  = 128;
    localparam int COMMAND_CHARS = 32;
    localparam int LINE_BYTES    = 256;

    localparam int ENTRY_W = $clog2(NUM_COMMANDS);
    localparam int CPOS_W  = $clog2(COMMAND_CHARS);
    localparam int LADDR_W = $clog2(LINE_BYTES);
    localparam int LPOS_W  = LADDR_W + 1;
    localparam int TADDR_W = ENTRY_W + CPOS_W;
    localparam int ECNT_W  = ENTRY_W + 1;

    localparam logic [1:0] REQ_RX_BYTE    = 2'd0;
    localparam logic [1:0] REQ_TABLE_CHAR = 2'd1;
    localparam logic [1:0] REQ_PARAM_FLAG = 2'd2;
    localparam logic [1:0] REQ_READ_LINE  = 2'd3;

    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_CLASS = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] ST_EXACT   = 2'd0;
    localparam logic [1:0] ST_PARAM   = 2'd1;
    localparam logic [1:0] ST_LOWER   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_T     = 8'h74;

    // Request from the control sequencer to the table walker.
    typedef struct packed {
        logic                start;
        logic                param_pass;
        logic [LPOS_W-1:0]   cmp_len;
        logic [ECNT_W-1:0]   count;
    } walk_req_t;

    typedef struct packed {
        logic               done;
        logic               found;
        logic [ENTRY_W-1:0] entry;
    } walk_rsp_t;

endpackage

### sv/clm_ram.sv
module clm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/clm_walker.sv
module clm_walker
    import clm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  walk_req_t          req,
    output walk_rsp_t          rsp,
    // line store read port
    output logic [LADDR_W-1:0] line_raddr,
    input  logic [7:0]         line_rdata,
    // table port
    output logic [TADDR_W-1:0] tab_raddr,
    input  logic [7:0]         tab_rdata,
    output logic [ENTRY_W-1:0] flag_raddr,
    input  logic               flag_rdata
);

    // Each character compare addresses the line and table (W_ADDR), then checks (W_CMP).
    typedef enum logic [3:0] {
        W_IDLE  = 4'b0001,
        W_ENTRY = 4'b0010,
        W_ADDR  = 4'b0100,
        W_CMP   = 4'b1000
    } wstate_t;

    wstate_t             state_reg, state_next;
    logic [ECNT_W-1:0]   entry_reg, entry_next;
    logic [CPOS_W-1:0]   pos_reg, pos_next;
    logic                param_reg, param_next;
    logic [LPOS_W-1:0]   len_reg, len_next;
    logic [ECNT_W-1:0]   count_reg, count_next;
    logic                done_reg, done_next;
    logic                found_reg, found_next;

    logic [LPOS_W-1:0] pos_ext;

    assign pos_ext    = LPOS_W'(pos_reg);
    assign line_raddr = LADDR_W'(pos_reg);
    assign tab_raddr  = {entry_reg[ENTRY_W-1:0], pos_reg};
    assign flag_raddr = entry_reg[ENTRY_W-1:0];

    assign rsp.done  = done_reg;
    assign rsp.found = found_reg;
    assign rsp.entry = entry_reg[ENTRY_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        entry_next = entry_reg;
        pos_next   = pos_reg;
        param_next = param_reg;
        len_next   = len_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        unique case (state_reg)
            W_IDLE:
            begin
                if (req.start)
                begin
                    entry_next = '0;
                    param_next = req.param_pass;
                    len_next   = req.cmp_len;
                    count_next = req.count;
                    found_next = 1'b0;
                    state_next = W_ENTRY;
                end
            end
            W_ENTRY:
            begin
                pos_next = '0;
                if (entry_reg >= count_reg)
                begin
                    done_next  = 1'b1;
                    state_next = W_IDLE;
                end
                else
                begin
                    state_next = W_ADDR;
                end
            end
            W_ADDR:
            begin
                state_next = W_CMP;
            end
            W_CMP:
            begin
                if (param_reg && !flag_rdata)
                begin
                    entry_next = entry_reg + 1'b1;
                    state_next = W_ENTRY;
                end
                else if (pos_ext == len_reg)
                begin
                    // Whole line matched; entry text must end here.
                    if (tab_rdata == 8'h00 || pos_reg == CPOS_W'(COMMAND_CHARS - 1))
                    begin
                        found_next = 1'b1;
                        done_next  = 1'b1;
                        state_next = W_IDLE;
                    end
                    else
                    begin
                        entry_next = entry_reg + 1'b1;
                        state_next = W_ENTRY;
                    end
                end
                else if (pos_reg == CPOS_W'(COMMAND_CHARS - 1) || tab_rdata == 8'h00 ||
                         tab_rdata != line_rdata)
                begin
                    entry_next = entry_reg + 1'b1;
                    state_next = W_ENTRY;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = W_ADDR;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            entry_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        param_reg <= param_next;
        len_reg   <= len_next;
        count_reg <= count_next;
    end

endmodule

### sv/command_line_matcher_core.sv
// A line end runs a scan of the line, one byte at a time, and up to two table
// walks, each comparing one character at a time through the entries in turn.
// The core takes one item at a time; ready stays low until all results are taken.
// Reset clears the line position, last line length and command count; the
// line store and command table are undefined until written.
module command_line_matcher_core
    import clm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   req_type,
    input  logic [7:0]   data_byte,
    input  logic [6:0]   entry_index,
    input  logic [4:0]   char_pos,
    input  logic         takes_param,
    input  logic [7:0]   line_index,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   kind,
    output logic [7:0]   out_byte,
    output logic [1:0]   match_status,
    output logic [6:0]   command_index,
    output logic [7:0]   param_start,
    output logic [7:0]   param_len,
    output logic [7:0]   line_len,
    output logic         last
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DISP   = 13'b0000000000010,
        S_RDWAIT = 13'b0000000000100,
        S_RDOUT  = 13'b0000000001000,
        S_SCANA  = 13'b0000000010000,
        S_SCANC  = 13'b0000000100000,
        S_EXACT  = 13'b0000001000000,
        S_EXWAIT = 13'b0000010000000,
        S_PARAM  = 13'b0000100000000,
        S_PWAIT  = 13'b0001000000000,
        S_QA     = 13'b0010000000000,
        S_QC     = 13'b0100000000000,
        S_EMIT   = 13'b1000000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [LPOS_W-1:0]  lpos_reg, lpos_next;
    logic [LPOS_W-1:0]  llen_reg, llen_next;
    logic [7:0]         count_reg;
    logic [1:0]         rq_reg;
    logic [7:0]         byte_reg;
    logic [6:0]         ent_reg;
    logic [4:0]         cpos_reg;
    logic               tp_reg;
    logic [7:0]         li_reg;

    // Scan results
    logic [LPOS_W-1:0]  sidx_reg, sidx_next;
    logic [7:0]         b0_reg, b0_next, b1_reg, b1_next, b2_reg, b2_next;
    logic [7:0]         bq0_reg, bq0_next;
    logic               eq_found_reg, eq_found_next;
    logic [LPOS_W-1:0]  eq_pos_reg, eq_pos_next;

    // Output queue: up to three results
    logic [1:0]         qn_reg, qn_next;
    logic [1:0]         qk_reg [3];
    logic [1:0]         qk_next [3];
    logic [7:0]         qb_reg [3];
    logic [7:0]         qb_next [3];
    logic               ql_reg [3];
    logic               ql_next [3];
    logic [1:0]         qs_reg, qs_next;
    logic [6:0]         qi_reg, qi_next;
    logic [7:0]         qps_reg, qps_next, qpl_reg, qpl_next, qll_reg, qll_next;

    walk_req_t          wreq;
    walk_rsp_t          wrsp;

    logic               lwe;
    logic [LADDR_W-1:0] lwaddr, lraddr, wk_lraddr;
    logic [7:0]         lrdata;
    logic               twe, fwe;
    logic [TADDR_W-1:0] traddr;
    logic [7:0]         trdata;
    logic [ENTRY_W-1:0] fraddr;
    logic [0:0]         frdata;
    logic               scan_mode;
    logic [LADDR_W-1:0] scan_addr;
    logic [LPOS_W-1:0]  vs, vl;
    logic [ECNT_W-1:0]  walk_count;
    logic               lower_err;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign walk_count = (count_reg > 8'(NUM_COMMANDS)) ? ECNT_W'(NUM_COMMANDS)
                                                       : ECNT_W'(count_reg);

    assign lwe    = (state_reg == S_DISP) && (rq_reg == REQ_RX_BYTE) &&
                    byte_reg != CH_CR && byte_reg != CH_LF && byte_reg != CH_BS &&
                    byte_reg != CH_DEL && (lpos_reg + 1'b1 < LPOS_W'(LINE_BYTES));
    assign lwaddr = lpos_reg[LADDR_W-1:0];
    assign twe    = (state_reg == S_DISP) && (rq_reg == REQ_TABLE_CHAR);
    assign fwe    = (state_reg == S_DISP) && (rq_reg == REQ_PARAM_FLAG);
    assign scan_mode = (state_reg == S_SCANA) || (state_reg == S_SCANC) ||
                       (state_reg == S_QA) || (state_reg == S_QC) ||
                       (state_reg == S_DISP) || (state_reg == S_RDWAIT);
    assign lraddr = scan_mode ? scan_addr : wk_lraddr;

    always_comb
    begin
        if (state_reg == S_DISP || state_reg == S_RDWAIT)
        begin
            scan_addr = li_reg[LADDR_W-1:0];
        end
        else if (state_reg == S_QA || state_reg == S_QC)
        begin
            scan_addr = LADDR_W'(llen_reg - 1'b1);
        end
        else
        begin
            scan_addr = sidx_reg[LADDR_W-1:0];
        end
    end

    clm_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line (
        .clk(clk), .we(lwe), .waddr(lwaddr), .wdata(byte_reg),
        .raddr(lraddr), .rdata(lrdata)
    );

    clm_ram #(.WIDTH(8), .DEPTH(NUM_COMMANDS * COMMAND_CHARS)) u_table (
        .clk(clk), .we(twe), .waddr({ent_reg, cpos_reg}), .wdata(byte_reg),
        .raddr(traddr), .rdata(trdata)
    );

    clm_ram #(.WIDTH(1), .DEPTH(NUM_COMMANDS)) u_flags (
        .clk(clk), .we(fwe), .waddr(ent_reg), .wdata(tp_reg),
        .raddr(fraddr), .rdata(frdata)
    );

    clm_walker u_walker (
        .clk(clk), .rst_n(rst_n), .req(wreq), .rsp(wrsp),
        .line_raddr(wk_lraddr), .line_rdata(lrdata),
        .tab_raddr(traddr), .tab_rdata(trdata),
        .flag_raddr(fraddr), .flag_rdata(frdata[0])
    );

    assign lower_err = (llen_reg >= LPOS_W'(2)) && b0_reg == CH_A && b1_reg == CH_T &&
                       (llen_reg == LPOS_W'(2) || b2_reg == CH_PLUS ||
                        b2_reg == CH_QUERY || b2_reg == CH_EQ);
    assign vs = eq_pos_reg + 1'b1;
    assign vl = llen_reg - eq_pos_reg - 1'b1;

    assign out_valid     = (state_reg == S_EMIT);
    assign kind          = qk_reg[0];
    assign out_byte      = qb_reg[0];
    assign last          = ql_reg[0];
    assign match_status  = (qk_reg[0] == KIND_CLASS) ? qs_reg : ST_EXACT;
    assign command_index = (qk_reg[0] == KIND_CLASS) ? qi_reg : 7'd0;
    assign param_start   = (qk_reg[0] == KIND_CLASS) ? qps_reg : 8'd0;
    assign param_len     = (qk_reg[0] == KIND_CLASS) ? qpl_reg : 8'd0;
    assign line_len      = (qk_reg[0] == KIND_CLASS) ? qll_reg : 8'd0;

    always_comb
    begin
        state_next    = state_reg;
        lpos_next     = lpos_reg;
        llen_next     = llen_reg;
        sidx_next     = sidx_reg;
        b0_next       = b0_reg;
        b1_next       = b1_reg;
        b2_next       = b2_reg;
        bq0_next      = bq0_reg;
        eq_found_next = eq_found_reg;
        eq_pos_next   = eq_pos_reg;
        qn_next       = qn_reg;
        qk_next       = qk_reg;
        qb_next       = qb_reg;
        ql_next       = ql_reg;
        qs_next       = qs_reg;
        qi_next       = qi_reg;
        qps_next      = qps_reg;
        qpl_next      = qpl_reg;
        qll_next      = qll_reg;
        wreq          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_IDLE;
                unique case (rq_reg) inside
                    REQ_READ_LINE:  state_next = S_RDWAIT;
                    REQ_TABLE_CHAR, REQ_PARAM_FLAG: state_next = S_IDLE;
                    default:
                    begin
                        if (byte_reg == CH_CR || byte_reg == CH_LF)
                        begin
                            qk_next = '{KIND_ECHO, KIND_ECHO, KIND_CLASS};
                            qb_next = '{CH_CR, CH_LF, 8'd0};
                            if (lpos_reg == '0)
                            begin
                                ql_next    = '{1'b0, 1'b1, 1'b0};
                                qn_next    = 2'd2;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                ql_next       = '{1'b0, 1'b0, 1'b1};
                                qn_next       = 2'd3;
                                llen_next     = lpos_reg;
                                qll_next      = lpos_reg[7:0];
                                lpos_next     = '0;
                                sidx_next     = '0;
                                bq0_next      = '0;
                                eq_found_next = 1'b0;
                                eq_pos_next   = '0;
                                qs_next       = ST_UNKNOWN;
                                qi_next       = '0;
                                qps_next      = '0;
                                qpl_next      = '0;
                                state_next    = S_SCANA;
                            end
                        end
                        else if (byte_reg == CH_BS || byte_reg == CH_DEL)
                        begin
                            if (lpos_reg != '0)
                            begin
                                lpos_next  = lpos_reg - 1'b1;
                                qk_next    = '{KIND_ECHO, KIND_ECHO, KIND_ECHO};
                                qb_next    = '{CH_BS, CH_SP, CH_BS};
                                ql_next    = '{1'b0, 1'b0, 1'b1};
                                qn_next    = 2'd3;
                                state_next = S_EMIT;
                            end
                        end
                        else if (lwe)
                        begin
                            lpos_next  = lpos_reg + 1'b1;
                            qk_next[0] = KIND_ECHO;
                            qb_next[0] = byte_reg;
                            ql_next[0] = 1'b1;
                            qn_next    = 2'd1;
                            state_next = S_EMIT;
                        end
                    end
                endcase
            end
            S_RDWAIT:
            begin
                state_next = S_RDOUT;
            end
            S_RDOUT:
            begin
                qk_next[0] = KIND_READ;
                qb_next[0] = ({1'b0, li_reg} < LPOS_W'(LINE_BYTES)) ? lrdata : 8'd0;
                ql_next[0] = 1'b1;
                qn_next    = 2'd1;
                state_next = S_EMIT;
            end
            S_SCANA:
            begin
                state_next = S_SCANC;
            end
            S_SCANC:
            begin
                if (sidx_reg == LPOS_W'(0)) b0_next = lrdata;
                if (sidx_reg == LPOS_W'(1)) b1_next = lrdata;
                if (sidx_reg == LPOS_W'(2)) b2_next = lrdata;
                // The byte just after the first '=' opens the parameter.
                if (eq_found_reg && sidx_reg == eq_pos_reg + 1'b1)
                begin
                    bq0_next = lrdata;
                end
                if (!eq_found_reg && lrdata == CH_EQ)
                begin
                    eq_found_next = 1'b1;
                    eq_pos_next   = sidx_reg;
                end
                if (sidx_reg + 1'b1 >= llen_reg)
                begin
                    state_next = S_EXACT;
                end
                else
                begin
                    sidx_next  = sidx_reg + 1'b1;
                    state_next = S_SCANA;
                end
            end
            S_EXACT:
            begin
                if (lower_err)
                begin
                    qs_next    = ST_LOWER;
                    state_next = S_EMIT;
                end
                else
                begin
                    wreq.start      = 1'b1;
                    wreq.param_pass = 1'b0;
                    wreq.cmp_len    = llen_reg;
                    wreq.count      = walk_count;
                    state_next      = S_EXWAIT;
                end
            end
            S_EXWAIT:
            begin
                if (wrsp.done)
                begin
                    if (wrsp.found)
                    begin
                        qs_next    = ST_EXACT;
                        qi_next    = 7'(wrsp.entry);
                        state_next = S_EMIT;
                    end
                    else if (eq_found_reg)
                    begin
                        state_next = S_PARAM;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_PARAM:
            begin
                wreq.start      = 1'b1;
                wreq.param_pass = 1'b1;
                wreq.cmp_len    = eq_pos_reg;
                wreq.count      = walk_count;
                state_next      = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (wrsp.done)
                begin
                    if (wrsp.found)
                    begin
                        qs_next    = ST_PARAM;
                        qi_next    = 7'(wrsp.entry);
                        qps_next   = vs[7:0];
                        qpl_next   = vl[7:0];
                        sidx_next  = vs;
                        state_next = S_QA;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_QA:
            begin
                // The last byte is addressed here; the first parameter byte was
                // kept during the scan.
                state_next = S_QC;
            end
            S_QC:
            begin
                if (vl >= LPOS_W'(2) && bq0_reg == CH_QUOTE && lrdata == CH_QUOTE)
                begin
                    qps_next = 8'(vs + 1'b1);
                    qpl_next = 8'(vl - LPOS_W'(2));
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    qk_next[0] = qk_reg[1];
                    qk_next[1] = qk_reg[2];
                    qb_next[0] = qb_reg[1];
                    qb_next[1] = qb_reg[2];
                    ql_next[0] = ql_reg[1];
                    ql_next[1] = ql_reg[2];
                    qn_next    = qn_reg - 1'b1;
                    if (qn_reg == 2'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lpos_reg  <= '0;
            llen_reg  <= '0;
            count_reg <= '0;
            qn_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lpos_reg  <= lpos_next;
            llen_reg  <= llen_next;
            qn_reg    <= qn_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rq_reg   <= req_type;
            byte_reg <= data_byte;
            ent_reg  <= entry_index;
            cpos_reg <= char_pos;
            tp_reg   <= takes_param;
            li_reg   <= line_index;
        end
        sidx_reg     <= sidx_next;
        b0_reg       <= b0_next;
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
        bq0_reg      <= bq0_next;
        eq_found_reg <= eq_found_next;
        eq_pos_reg   <= eq_pos_next;
        qk_reg       <= qk_next;
        qb_reg       <= qb_next;
        ql_reg       <= ql_next;
        qs_reg       <= qs_next;
        qi_reg       <= qi_next;
        qps_reg      <= qps_next;
        qpl_reg      <= qpl_next;
        qll_reg      <= qll_next;
    end

endmodule

### sim/testbench.sv
module testbench;
    import clm_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] data;
        logic [6:0] ent;
        logic [4:0] pos;
        logic       tp;
        logic [7:0] li;
    } request_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ob;
        logic [1:0] status;
        logic [6:0] cidx;
        logic [7:0] pstart;
        logic [7:0] plen;
        logic [7:0] llen;
        logic       lst;
    } response_t;

    typedef struct {
        request_t   r;
        bit         chk;
        logic [1:0] kind;
        logic [7:0] ob;
        logic [1:0] status;
    } plan_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] req_type = 2'd0;
    logic [7:0] data_byte = 8'd0;
    logic [6:0] entry_index = 7'd0;
    logic [4:0] char_pos = 5'd0;
    logic       takes_param = 1'b0;
    logic [7:0] line_index = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] match_status;
    logic [6:0] command_index;
    logic [7:0] param_start;
    logic [7:0] param_len;
    logic [7:0] line_len;
    logic       last;

    // Predictor state.
    logic [7:0] line_mem [LINE_BYTES];
    bit         line_written [LINE_BYTES];
    int         line_pos;
    int         search_count;
    logic [7:0] cmd_text [NUM_COMMANDS][COMMAND_CHARS];
    bit         cmd_flag [NUM_COMMANDS];

    response_t  pending_q[$];
    response_t  last_seen;
    int         failures;
    int         sent;
    int         idle_cycles;
    bit         pressure_req;
    string      names [8];
    plan_row_t  plan [25];

    always #6 clk = ~clk;

    command_line_matcher_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .data_byte(data_byte), .entry_index(entry_index),
        .char_pos(char_pos), .takes_param(takes_param), .line_index(line_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .out_byte(out_byte), .match_status(match_status),
        .command_index(command_index), .param_start(param_start),
        .param_len(param_len), .line_len(line_len), .last(last)
    );

    function automatic void add_response(int k, int ob, int st, int ci, int ps, int pl,
                                         int ll, int l);
        response_t r;
        r.kind = 2'(k);
        r.ob = 8'(ob);
        r.status = 2'(st);
        r.cidx = 7'(ci);
        r.pstart = 8'(ps);
        r.plen = 8'(pl);
        r.llen = 8'(ll);
        r.lst = 1'(l);
        pending_q.push_back(r);
    endfunction

    function automatic bit entry_matches(int e, int len);
        int n;
        n = 0;
        while (n + 1 < COMMAND_CHARS && cmd_text[e][n] != 8'd0)
            n++;
        if (n != len)
            return 0;
        for (int k = 0; k < len; k++)
            if (cmd_text[e][k] != line_mem[k])
                return 0;
        return 1;
    endfunction

    function automatic void classify_line(int len);
        int n, j, vs, vl;
        n = search_count < NUM_COMMANDS ? search_count : NUM_COMMANDS;
        if (len >= 2 && line_mem[0] == CH_A && line_mem[1] == CH_T &&
            (len == 2 || line_mem[2] == CH_PLUS || line_mem[2] == CH_QUERY ||
             line_mem[2] == CH_EQ)) begin
            add_response(KIND_CLASS, 0, ST_LOWER, 0, 0, 0, len, 1);
            return;
        end
        for (int i = 0; i < n; i++)
            if (entry_matches(i, len)) begin
                add_response(KIND_CLASS, 0, ST_EXACT, i, 0, 0, len, 1);
                return;
            end
        j = 0;
        while (j < len && line_mem[j] != CH_EQ)
            j++;
        if (j < len)
            for (int i = 0; i < n; i++)
                if (cmd_flag[i] && entry_matches(i, j)) begin
                    vs = j + 1;
                    vl = len - j - 1;
                    if (vl >= 2 && line_mem[vs] == CH_QUOTE && line_mem[len-1] == CH_QUOTE)
                    begin
                        vs++;
                        vl -= 2;
                    end
                    add_response(KIND_CLASS, 0, ST_PARAM, i, vs, vl, len, 1);
                    return;
                end
        add_response(KIND_CLASS, 0, ST_UNKNOWN, 0, 0, 0, len, 1);
    endfunction

    function automatic void predict_results(request_t it);
        int len;
        case (it.req)
            REQ_TABLE_CHAR: cmd_text[it.ent][it.pos] = it.data;
            REQ_PARAM_FLAG: cmd_flag[it.ent] = it.tp;
            REQ_READ_LINE:  add_response(KIND_READ, line_mem[it.li], 0, 0, 0, 0, 0, 1);
            default: begin
                if (it.data == CH_CR || it.data == CH_LF) begin
                    len = line_pos;
                    add_response(KIND_ECHO, CH_CR, 0, 0, 0, 0, 0, 0);
                    add_response(KIND_ECHO, CH_LF, 0, 0, 0, 0, 0, len == 0);
                    if (len != 0) begin
                        line_pos = 0;
                        classify_line(len);
                    end
                end else if (it.data == CH_BS || it.data == CH_DEL) begin
                    if (line_pos > 0) begin
                        line_pos--;
                        add_response(KIND_ECHO, CH_BS, 0, 0, 0, 0, 0, 0);
                        add_response(KIND_ECHO, CH_SP, 0, 0, 0, 0, 0, 0);
                        add_response(KIND_ECHO, CH_BS, 0, 0, 0, 0, 0, 1);
                    end
                end else if (line_pos + 1 < LINE_BYTES) begin
                    line_mem[line_pos] = it.data;
                    line_written[line_pos] = 1;
                    line_pos++;
                    add_response(KIND_ECHO, it.data, 0, 0, 0, 0, 0, 1);
                end
            end
        endcase
    endfunction

    always @(posedge clk) begin
        response_t got, want;
        bit moved;
        moved = 0;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                predict_results({req_type, data_byte, entry_index, char_pos,
                                 takes_param, line_index});
                moved = 1;
            end
            if (cfg_valid && cfg_ready) begin
                search_count = cfg_data;
                moved = 1;
            end
            if (out_valid && out_ready) begin
                moved = 1;
                got = {kind, out_byte, match_status, command_index, param_start,
                       param_len, line_len, last};
                last_seen = got;
                if (pending_q.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %p", $time, got);
                    failures++;
                end else begin
                    want = pending_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %p", $time, want);
                        $display("%0t:           actual   %p", $time, got);
                        failures++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side: random stalls, calm stretches and one long hold-off on request.
    always @(negedge clk) begin
        int r;
        int hold;
        int calm;
        if (pressure_req) begin
            hold = 400;
            pressure_req = 0;
        end
        if (hold > 0) begin
            out_ready = 1'b0;
            hold--;
        end else if (calm > 0) begin
            out_ready = 1'b1;
            calm--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3)
                calm = $urandom_range(50, 200);
            else if (r < 7)
                hold = $urandom_range(20, 80);
            else if (r < 30)
                hold = $urandom_range(1, 3);
            out_ready = (hold == 0);
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(input request_t it);
        int g;
        g = gap_len();
        repeat (g) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        {req_type, data_byte, entry_index, char_pos, takes_param, line_index} = it;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    function automatic request_t make_req(logic [1:0] req, logic [7:0] data);
        request_t it;
        it.req = req;
        it.data = data;
        it.ent = 7'($urandom);
        it.pos = 5'($urandom);
        it.tp = 1'($urandom);
        it.li = 8'($urandom);
        return it;
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_count(input logic [7:0] v);
        wait_idle();
        cfg_data = v;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_entry(input int e, input string s, input bit p);
        request_t it;
        for (int i = 0; i <= s.len() && i < COMMAND_CHARS; i++) begin
            it = make_req(REQ_TABLE_CHAR, i < s.len() ? s[i] : 8'd0);
            // A full-length name still gets a character in the final slot.
            if (i == COMMAND_CHARS - 1)
                it.data = 8'h51;
            it.ent = 7'(e);
            it.pos = 5'(i);
            send(it);
        end
        it = make_req(REQ_PARAM_FLAG, 8'($urandom));
        it.ent = 7'(e);
        it.tp = p;
        send(it);
    endtask

    task automatic read_written_byte();
        request_t it;
        int k;
        do k = $urandom_range(0, LINE_BYTES - 1); while (!line_written[k]);
        it = make_req(REQ_READ_LINE, 8'($urandom));
        it.li = 8'(k);
        send(it);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic random_line();
        logic [7:0] bytes[$];
        request_t   it;
        string      nm;
        int         r, n;
        bit         quoted;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            nm = names[$urandom_range(0, 7)];
            for (int i = 0; i < nm.len(); i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    bytes.push_back(printable());
                    bytes.push_back($urandom_range(0, 1) ? CH_BS : CH_DEL);
                end
                bytes.push_back(nm[i]);
            end
            if ($urandom_range(0, 2) != 0) begin
                bytes.push_back(CH_EQ);
                quoted = $urandom_range(0, 1);
                if (quoted)
                    bytes.push_back(CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) bytes.push_back(printable());
                if (quoted)
                    bytes.push_back(CH_QUOTE);
            end
        end else if (r < 62) begin
            bytes.push_back(CH_A);
            bytes.push_back(CH_T);
            case ($urandom_range(0, 4))
                0: bytes.push_back(CH_PLUS);
                1: bytes.push_back(CH_QUERY);
                2: bytes.push_back(CH_EQ);
                3: bytes.push_back(8'h7A);
                default: ;
            endcase
            repeat ($urandom_range(0, 3)) bytes.push_back(printable());
        end else if (r < 72) begin
            bytes.push_back(CH_EQ);
            repeat ($urandom_range(0, 5)) bytes.push_back(printable());
        end else if (r < 87) begin
            repeat ($urandom_range(0, 10)) bytes.push_back(8'($urandom));
        end else if (r < 94) begin
            read_written_byte();
            return;
        end else begin
            // Table traffic that leaves every searched name intact.
            if ($urandom_range(0, 1)) begin
                it = make_req(REQ_TABLE_CHAR, 8'($urandom));
                it.pos = 5'(COMMAND_CHARS - 1);
            end else begin
                it = make_req(REQ_PARAM_FLAG, 8'($urandom));
                it.ent = 7'($urandom_range(8, NUM_COMMANDS - 1));
            end
            send(it);
            return;
        end
        bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        foreach (bytes[i])
            send(make_req(REQ_RX_BYTE, bytes[i]));
    endtask

    initial begin
        int stop_at;
        names[0] = "AT";
        names[1] = "AT+C";
        names[2] = "AT+GMR";
        names[3] = "AT+CWJAP";
        names[4] = "AT+RST";
        names[5] = {"AT+", "ZZZZZZZZZZ", "ZZZZZZZZZZ", "ZZZZZZZZ"};
        names[6] = "ATE0";
        names[7] = "AT+X?";

        plan[0]  = '{'{REQ_RX_BYTE, CH_LF, 0, 0, 0, 0}, 1, KIND_ECHO, CH_LF, ST_EXACT};
        plan[1]  = '{'{REQ_RX_BYTE, CH_DEL, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[2]  = '{'{REQ_RX_BYTE, CH_BS, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[3]  = '{'{REQ_RX_BYTE, CH_A, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[4]  = '{'{REQ_RX_BYTE, CH_T, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[5]  = '{'{REQ_RX_BYTE, CH_CR, 0, 0, 0, 0}, 1, KIND_CLASS, 8'd0, ST_LOWER};
        plan[6]  = '{'{REQ_READ_LINE, 8'hFF, 7'h7F, 5'h1F, 1, 0}, 1, KIND_READ, CH_A,
                     ST_EXACT};
        plan[7]  = '{'{REQ_RX_BYTE, 8'h41, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[8]  = '{'{REQ_RX_BYTE, 8'h54, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[9]  = '{'{REQ_RX_BYTE, CH_LF, 0, 0, 0, 0}, 1, KIND_CLASS, 8'd0, ST_EXACT};
        plan[10] = '{'{REQ_RX_BYTE, 8'h58, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[11] = '{'{REQ_RX_BYTE, CH_BS, 0, 0, 0, 0}, 1, KIND_ECHO, CH_BS, ST_EXACT};
        plan[12] = '{'{REQ_RX_BYTE, 8'h00, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[13] = '{'{REQ_RX_BYTE, 8'hFF, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[14] = '{'{REQ_RX_BYTE, CH_CR, 0, 0, 0, 0}, 1, KIND_CLASS, 8'd0, ST_UNKNOWN};
        plan[15] = '{'{REQ_RX_BYTE, 8'h41, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[16] = '{'{REQ_RX_BYTE, 8'h54, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[17] = '{'{REQ_RX_BYTE, CH_PLUS, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[18] = '{'{REQ_RX_BYTE, 8'h43, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[19] = '{'{REQ_RX_BYTE, CH_EQ, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[20] = '{'{REQ_RX_BYTE, CH_QUOTE, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[21] = '{'{REQ_RX_BYTE, CH_QUOTE, 0, 0, 0, 0}, 0, 0, 0, 0};
        plan[22] = '{'{REQ_RX_BYTE, CH_CR, 0, 0, 0, 0}, 1, KIND_CLASS, 8'd0, ST_PARAM};
        plan[23] = '{'{REQ_TABLE_CHAR, 8'hFF, 7'h7F, 5'h1F, 1, 8'hFF}, 0, 0, 0, 0};
        plan[24] = '{'{REQ_PARAM_FLAG, 8'h00, 7'h7F, 5'h00, 1, 8'h00}, 0, 0, 0, 0};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_count(8'd0);
        for (int e = 0; e < 8; e++)
            write_entry(e, names[e], e == 1 || e == 3 || e == 7);
        write_count(8'd8);

        foreach (plan[i]) begin
            send(plan[i].r);
            if (plan[i].chk) begin
                @(negedge clk);
                in_valid = 1'b0;
                while (pending_q.size() != 0)
                    @(negedge clk);
                if (last_seen.kind !== plan[i].kind || last_seen.ob !== plan[i].ob ||
                    last_seen.status !== plan[i].status) begin
                    $display("%0t: step %0d expected kind %0d byte %h status %0d", $time,
                             i, plan[i].kind, plan[i].ob, plan[i].status);
                    $display("%0t: step %0d actual   kind %0d byte %h status %0d", $time,
                             i, last_seen.kind, last_seen.ob, last_seen.status);
                    failures++;
                end
            end
        end

        // The long result stall starts while lines keep arriving.
        pressure_req = 1;
        stop_at = sent + 60;
        while (sent < stop_at)
            random_line();

        write_count(8'd0);
        repeat (3) random_line();

        // A count above the table size; this line matches the first entry.
        write_count(8'd255);
        send(make_req(REQ_RX_BYTE, 8'h41));
        send(make_req(REQ_RX_BYTE, 8'h54));
        send(make_req(REQ_RX_BYTE, CH_CR));

        wait_idle();
        repeat (40) @(posedge clk);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
sv/clm_pkg.sv
sv/clm_ram.sv
sv/clm_walker.sv
sv/command_line_matcher_core.sv
sim/testbench.sv
